// File: src/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared types and constants of the miller-rabin prime test block
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int CNT_W     = $clog2(NUM_WIDTH + 1);

    typedef logic [NUM_WIDTH-1:0] num_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED,
        ST_SPLIT,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_SQR,
        ST_CHECK,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage

// File: src/mrpt_mulmod.sv
// ----------------------------------------------------------------------------
// mrpt_mulmod
// bit-serial modular multiplier: one double-and-add step per cycle
// ----------------------------------------------------------------------------
module mrpt_mulmod
    import mrpt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  num_t x,
    input  num_t y,
    input  num_t m,
    output logic done,
    output num_t prod
);

    num_t acc_reg, acc_next;
    num_t x_reg, y_reg, m_reg;
    cnt_t bit_reg, bit_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    logic [NUM_WIDTH:0] dbl, dbl_red, sum, sum_red;
    num_t acc_d;

    always_comb
    begin
        dbl      = {1'b0, acc_reg} + {1'b0, acc_reg};
        dbl_red  = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        acc_d    = dbl_red[NUM_WIDTH-1:0];
        sum      = {1'b0, acc_d} + {1'b0, x_reg};
        sum_red  = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
        acc_next = acc_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            bit_next  = cnt_t'(NUM_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = y_reg[NUM_WIDTH-1] ? sum_red[NUM_WIDTH-1:0] : acc_d;
            bit_next = bit_reg - cnt_t'(1);
            if (bit_reg == cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
        end
        else if (busy_reg)
        begin
            y_reg <= {y_reg[NUM_WIDTH-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: src/miller_rabin_prime_test_top.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_top
// miller-rabin witness round on a shared bit-serial modular multiplier
// ----------------------------------------------------------------------------
// channel   dir  signals                 beat contents
// s_axis    in   tvalid tready tdata     candidate, witness
//                tlast                   last_witness
// m_axis    out  tvalid tready tdata     probably_prime
//
// a witness needs up to about 2*64 products on the one multiplier plus one
// reduction of the witness; a small candidate skips the multiplier. ready is
// low while a beat is in work; a verdict waits in the output register while
// the next beat is taken, and a new verdict stalls until it has gone. no
// reset of payload registers.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_top
    import mrpt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] candidate, [127:64] witness
    input  logic         s_axis_tlast,  // last_witness
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // [0] probably_prime, [7:1] zero
);

    state_t state_reg, state_next;
    num_t n_reg, n_next, a_reg, a_next, d_reg, d_next, x_reg, x_next;
    cnt_t s_reg, s_next, i_reg, i_next;
    logic last_reg, last_next, pass_reg, pass_next, fail_reg, fail_next;
    logic verdict_reg, verdict_next, valid_reg, valid_next;

    logic   mm_start, mm_done;
    num_t   mm_x, mm_y, mm_prod;
    num_t   nm1;

    mrpt_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .x     (mm_x),
        .y     (mm_y),
        .m     (n_reg),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    assign nm1 = n_reg - num_t'(1);

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        a_next       = a_reg;
        d_next       = d_reg;
        x_next       = x_reg;
        s_next       = s_reg;
        i_next       = i_reg;
        last_next    = last_reg;
        pass_next    = pass_reg;
        fail_next    = fail_reg;
        verdict_next = verdict_reg;
        valid_next   = valid_reg;
        mm_start     = 1'b0;
        mm_x         = a_reg;
        mm_y         = num_t'(1);
        s_axis_tready = (state_reg == ST_IDLE);
        if (valid_reg && m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    n_next    = s_axis_tdata[NUM_WIDTH-1:0];
                    a_next    = s_axis_tdata[64 +: NUM_WIDTH];
                    last_next = s_axis_tlast;
                    fail_next = 1'b0;
                    if (s_axis_tdata[NUM_WIDTH-1:0] > num_t'(4))
                    begin
                        // a mod n as a*1 mod n; the multiplier needs x below m only
                        // for the add, a wider a reduces through doubling anyway
                        d_next     = s_axis_tdata[NUM_WIDTH-1:0] - num_t'(1);
                        s_next     = '0;
                        state_next = ST_RED;
                    end
                    else
                    begin
                        // small candidate leaves the sticky flag alone unless last
                        fail_next  = s_axis_tlast &&
                                     !((s_axis_tdata[NUM_WIDTH-1:0] == num_t'(2)) ||
                                       (s_axis_tdata[NUM_WIDTH-1:0] == num_t'(3)));
                        state_next = ST_OUT;
                    end
                end
            end
            ST_RED:
            begin
                // reduce witness: a mod n via shift-subtract, one bit a step
                mm_x       = num_t'(1);
                mm_y       = a_reg;
                mm_start   = 1'b1;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (mm_done)
                begin
                    a_next = mm_prod;
                    x_next = num_t'(1);
                end
                if (d_reg[0] == 1'b0)
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + cnt_t'(1);
                end
                else if (mm_done)
                begin
                    state_next = ST_POW_MUL;
                    mm_x       = num_t'(1);
                end
            end
            ST_POW_MUL:
            begin
                if (d_reg == '0)
                begin
                    i_next     = '0;
                    state_next = (s_reg == '0) ? ST_DONE : ST_SQR;
                    if (s_reg != '0)
                    begin
                        mm_x     = x_reg;
                        mm_y     = x_reg;
                        mm_start = 1'b1;
                    end
                end
                else if (d_reg[0])
                begin
                    mm_x       = x_reg;
                    mm_y       = a_reg;
                    mm_start   = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    mm_x       = a_reg;
                    mm_y       = a_reg;
                    mm_start   = 1'b1;
                    state_next = ST_POW_SQR;
                end
            end
            ST_CHECK:
            begin
                if (mm_done)
                begin
                    x_next     = mm_prod;
                    mm_x       = a_reg;
                    mm_y       = a_reg;
                    mm_start   = 1'b1;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                if (mm_done)
                begin
                    a_next     = mm_prod;
                    d_next     = d_reg >> 1;
                    state_next = ST_POW_MUL;
                end
            end
            ST_SQR:
            begin
                if (mm_done)
                begin
                    if ((mm_prod == num_t'(1)) && (x_reg != num_t'(1)) && (x_reg != nm1))
                    begin
                        fail_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        x_next = mm_prod;
                        i_next = i_reg + cnt_t'(1);
                        if (i_reg + cnt_t'(1) == s_reg)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            mm_x     = mm_prod;
                            mm_y     = mm_prod;
                            mm_start = 1'b1;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                fail_next  = (x_reg != num_t'(1));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (last_reg)
                begin
                    if (!valid_reg)
                    begin
                        verdict_next = pass_reg && !fail_reg;
                        valid_next   = 1'b1;
                        pass_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    pass_next  = pass_reg && !fail_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pass_reg  <= 1'b1;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        a_reg       <= a_next;
        d_reg       <= d_next;
        x_reg       <= x_next;
        s_reg       <= s_next;
        i_reg       <= i_next;
        last_reg    <= last_next;
        fail_reg    <= fail_next;
        verdict_reg <= verdict_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, verdict_reg};

endmodule
